### src/pdfc_pkg.sv
// shared constants, types and control structs of the deadband force coder
// no dependencies

package pdfc_pkg;

  localparam int FORCE_WIDTH = 16;
  localparam int K_W = 10;
  localparam int K_FRAC_SHIFT = 2 * K_W;
  localparam logic [K_W-1:0] K_RESET = K_W'(205);

  // difference magnitude and sum-of-squares widths
  localparam int D_W = FORCE_WIDTH + 1;
  localparam int DD_W = 2 * D_W;
  localparam int FF_W = 2 * FORCE_WIDTH;
  localparam int K2_W = 2 * K_W;
  localparam int PROD_W = K2_W + FF_W;
  localparam int ACC_W = PROD_W;
  localparam int SER_W = (K2_W > D_W) ? K2_W : D_W;
  localparam int LHS_W = DD_W + K_FRAC_SHIFT;
  localparam int CMP_W = (LHS_W > PROD_W) ? LHS_W : PROD_W;

  typedef logic signed [FORCE_WIDTH-1:0] force_t;
  typedef logic [K_W-1:0] kfrac_t;

  typedef struct packed {
    logic start;
    logic clr;
  } mac_ctl_t;

endpackage

### src/pdfc_ifs.sv
// handshake channels of the deadband force coder: sample, result, config
// depends on pdfc_pkg

interface pdfc_force_if;
  import pdfc_pkg::*;
  logic   valid;
  logic   ready;
  force_t force_x;
  force_t force_y;
  force_t force_z;
  modport source (output valid, output force_x, output force_y, output force_z, input ready);
  modport sink (input valid, input force_x, input force_y, input force_z, output ready);
endinterface

interface pdfc_held_if;
  import pdfc_pkg::*;
  logic   valid;
  logic   ready;
  force_t held_x;
  force_t held_y;
  force_t held_z;
  logic   send_update;
  modport source (output valid, output held_x, output held_y, output held_z,
                  output send_update, input ready);
  modport sink (input valid, input held_x, input held_y, input held_z,
                input send_update, output ready);
endinterface

interface pdfc_cfg_if;
  import pdfc_pkg::*;
  logic   valid;
  logic   ready;
  kfrac_t deadband_fraction;
  modport source (output valid, output deadband_fraction, input ready);
  modport sink (input valid, input deadband_fraction, output ready);
endinterface

### src/pdfc_mac.sv
// bit-serial shift-add multiply-accumulate unit, one multiplier bit per cycle
// depends on pdfc_pkg

module pdfc_mac (
  input  logic                    clk,
  input  logic                    rst,
  input  pdfc_pkg::mac_ctl_t      ctl,
  input  logic [pdfc_pkg::ACC_W-1:0] mcd_in,
  input  logic [pdfc_pkg::SER_W-1:0] ser_in,
  output logic                    busy,
  output logic [pdfc_pkg::ACC_W-1:0] acc
);
  import pdfc_pkg::*;

  logic [ACC_W-1:0] mcd;
  logic [SER_W-1:0] ser;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      mcd  <= mcd_in;
      ser  <= ser_in;
      busy <= 1'b1;
      if (ctl.clr) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (ser[0]) begin
        acc <= acc + mcd;
      end
      mcd <= {mcd[ACC_W-2:0], 1'b0};
      ser <= {1'b0, ser[SER_W-1:1]};
      if (ser[SER_W-1:1] == '0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### src/perceptual_deadband_force_coder_unit.sv
// top level of the perceptual deadband force coder: sequencer and output register
// depends on pdfc_pkg, pdfc_ifs, pdfc_mac
//
//   channel  | dir | carries
//   sample   | in  | force_x, force_y, force_z
//   result   | out | held_x, held_y, held_z, send_update
//   cfg      | in  | deadband_fraction, always ready
//
// one word at a time, through the bit-serial mac:
// eight products (three difference squares, three force squares, k*k, k^2*ff)
// at one multiplier bit per cycle, each issued and run in turn
// reset: held force zero, first sample pending, deadband_fraction 205
// a finished word waits in the output register; a new sample is taken meanwhile

module perceptual_deadband_force_coder_unit (
  input logic           clk,
  input logic           rst,
  pdfc_force_if.sink    sample,
  pdfc_held_if.source   result,
  pdfc_cfg_if.sink      cfg
);
  import pdfc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_RUN, ST_DONE} state_t;
  typedef enum logic [2:0] {
    SQ_DX, SQ_DY, SQ_DZ, SQ_FX, SQ_FY, SQ_FZ, SQ_K, MUL_KF
  } step_t;

  state_t state;
  step_t  step;

  kfrac_t k;
  force_t f_x, f_y, f_z;
  force_t h_x, h_y, h_z;
  logic   first;
  logic [DD_W-1:0] dd;
  logic [FF_W-1:0] ff;
  logic [K2_W-1:0] k2;

  logic   out_valid;
  force_t out_x, out_y, out_z;
  logic   out_send;

  mac_ctl_t         mac_ctl;
  logic [ACC_W-1:0] mcd_in;
  logic [SER_W-1:0] ser_in;
  logic             mac_busy;
  logic [ACC_W-1:0] acc;

  force_t                 sel_f, sel_h;
  logic signed [D_W-1:0]  dif;
  logic [D_W-1:0]         mag_d;
  logic [FORCE_WIDTH-1:0] mag_f;
  logic [CMP_W-1:0]       lhs, rhs;
  logic                   send;
  logic                   out_load;

  // config register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= K_RESET;
    end else if (cfg.valid) begin
      k <= cfg.deadband_fraction;
    end
  end

  // axis select for the current product
  always_comb begin
    unique case (step)
      SQ_DX, SQ_FX: begin sel_f = f_x; sel_h = h_x; end
      SQ_DY, SQ_FY: begin sel_f = f_y; sel_h = h_y; end
      default:      begin sel_f = f_z; sel_h = h_z; end
    endcase
  end

  assign dif   = {sel_f[FORCE_WIDTH-1], sel_f} - {sel_h[FORCE_WIDTH-1], sel_h};
  assign mag_d = dif[D_W-1] ? D_W'(-dif) : D_W'(dif);
  assign mag_f = sel_f[FORCE_WIDTH-1] ? FORCE_WIDTH'(-sel_f) : FORCE_WIDTH'(sel_f);

  // mac operands
  always_comb begin
    mac_ctl.start = (state == ST_ISSUE);
    unique case (step)
      SQ_DX, SQ_DY, SQ_DZ: begin
        mac_ctl.clr = (step == SQ_DX);
        mcd_in      = ACC_W'(mag_d);
        ser_in      = SER_W'(mag_d);
      end
      SQ_FX, SQ_FY, SQ_FZ: begin
        mac_ctl.clr = (step == SQ_FX);
        mcd_in      = ACC_W'(mag_f);
        ser_in      = SER_W'(mag_f);
      end
      SQ_K: begin
        mac_ctl.clr = 1'b1;
        mcd_in      = ACC_W'(k);
        ser_in      = SER_W'(k);
      end
      default: begin
        mac_ctl.clr = 1'b1;
        mcd_in      = ACC_W'(ff);
        ser_in      = SER_W'(k2);
      end
    endcase
  end

  pdfc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .mcd_in (mcd_in),
    .ser_in (ser_in),
    .busy   (mac_busy),
    .acc    (acc)
  );

  // |f-h|^2 * 2^20 > k^2 * |f|^2
  assign lhs      = CMP_W'({dd, {K_FRAC_SHIFT{1'b0}}});
  assign rhs      = CMP_W'(acc);
  assign send     = first || (lhs > rhs);
  assign out_load = (state == ST_DONE) && (!out_valid || result.ready);

  assign sample.ready       = (state == ST_IDLE);
  assign result.valid       = out_valid;
  assign result.held_x      = out_x;
  assign result.held_y      = out_y;
  assign result.held_z      = out_z;
  assign result.send_update = out_send;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= SQ_DX;
      first     <= 1'b1;
      h_x       <= '0;
      h_y       <= '0;
      h_z       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            f_x   <= sample.force_x;
            f_y   <= sample.force_y;
            f_z   <= sample.force_z;
            step  <= SQ_DX;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (!mac_busy) begin
            if (step == SQ_DZ) begin
              dd <= acc[DD_W-1:0];
            end
            if (step == SQ_FZ) begin
              ff <= acc[FF_W-1:0];
            end
            if (step == SQ_K) begin
              k2 <= acc[K2_W-1:0];
            end
            if (step == MUL_KF) begin
              state <= ST_DONE;
            end else begin
              step  <= step_t'(step + 3'd1);
              state <= ST_ISSUE;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            if (send) begin
              h_x <= f_x;
              h_y <= f_y;
              h_z <= f_z;
            end
            out_x     <= send ? f_x : h_x;
            out_y     <= send ? f_y : h_y;
            out_z     <= send ? f_z : h_z;
            out_send  <= send;
            out_valid <= 1'b1;
            first     <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_mac_no_restart: assert property (@(posedge clk) disable iff (rst)
    mac_ctl.start |-> !mac_busy)
    else $error("mac started while busy");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    mac_busy |-> !sample.ready)
    else $error("sample taken while mac busy");

  a_first_cleared: assert property (@(posedge clk) disable iff (rst)
    out_load |=> !first)
    else $error("first sample flag not cleared");

  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    (out_load && !send) |=> (h_x == $past(h_x) && h_y == $past(h_y) && h_z == $past(h_z)))
    else $error("held force changed without update");

endmodule

### tb/perceptual_deadband_force_coder_unit_test.sv
// self-checking test of the deadband force coder: directed corner words, then random words
// under three idle patterns and several deadband fractions, checked against a scoreboard
// depends on pdfc_pkg, pdfc_ifs and perceptual_deadband_force_coder_unit

module perceptual_deadband_force_coder_unit_test;
  import pdfc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_WORDS = 265;

  typedef struct {
    force_t x;
    force_t y;
    force_t z;
    logic   upd;
  } held_word_t;

  class deadband_scoreboard;
    force_t     held [3];
    bit         pending_first;
    kfrac_t     fraction;
    held_word_t expected_words [$];
    int         errors;

    function new();
      held = '{default: '0};
      pending_first = 1'b1;
      fraction = K_RESET;
      errors = 0;
    endfunction

    function void set_fraction(kfrac_t k);
      fraction = k;
    endfunction

    function void note_sample(force_t fx, force_t fy, force_t fz);
      force_t     f [3];
      longint     d;
      longint     dist_sq;
      longint     mag_sq;
      longint     lhs;
      longint     rhs;
      bit         upd;
      held_word_t w;
      f = '{fx, fy, fz};
      dist_sq = 0;
      mag_sq = 0;
      for (int i = 0; i < 3; i++) begin
        d = longint'(f[i]) - longint'(held[i]);
        dist_sq += d * d;
        mag_sq += longint'(f[i]) * longint'(f[i]);
      end
      lhs = dist_sq << K_FRAC_SHIFT;
      rhs = longint'(fraction) * longint'(fraction) * mag_sq;
      upd = pending_first || (lhs > rhs);
      if (upd) begin
        held = f;
      end
      pending_first = 1'b0;
      w.x = held[0];
      w.y = held[1];
      w.z = held[2];
      w.upd = upd;
      expected_words.push_back(w);
    endfunction

    function void check_word(force_t hx, force_t hy, force_t hz, logic upd);
      held_word_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: held %0d %0d %0d send_update %0b", hx, hy, hz, upd);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (hx !== w.x) begin
        $error("held_x: expected %0d, got %0d", w.x, hx);
        errors++;
      end
      if (hy !== w.y) begin
        $error("held_y: expected %0d, got %0d", w.y, hy);
        errors++;
      end
      if (hz !== w.z) begin
        $error("held_z: expected %0d, got %0d", w.z, hz);
        errors++;
      end
      if (upd !== w.upd) begin
        $error("send_update: expected %0b, got %0b", w.upd, upd);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   quiet_cycles;

  deadband_scoreboard sb;

  pdfc_force_if sample_ch ();
  pdfc_held_if  result_ch ();
  pdfc_cfg_if   cfg_ch ();

  perceptual_deadband_force_coder_unit dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        sb.check_word(result_ch.held_x, result_ch.held_y, result_ch.held_z,
                      result_ch.send_update);
      end
      result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** perceptual_deadband_force_coder_unit: FAILED **");
      $finish;
    end
  end

  task automatic push_sample(force_t fx, force_t fy, force_t fz);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.force_x <= fx;
    sample_ch.force_y <= fy;
    sample_ch.force_z <= fz;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sb.note_sample(fx, fy, fz);
  endtask

  task automatic write_fraction(kfrac_t k);
    cfg_ch.valid <= 1'b1;
    cfg_ch.deadband_fraction <= k;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_fraction(k);
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic force_t near_value(force_t h);
    int span;
    int v;
    span = 1 << $urandom_range(14, 0);
    v = int'(h) + int'($urandom_range(2 * span, 0)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return force_t'(v);
  endfunction

  function automatic force_t corner_value();
    case ($urandom_range(4, 0))
      0: return force_t'(-32768);
      1: return force_t'(32767);
      2: return force_t'(0);
      3: return force_t'(-1);
      default: return force_t'(1);
    endcase
  endfunction

  task automatic run_random(int count, int src_pct, int sink_pct);
    force_t f [3];
    int     roll;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      for (int i = 0; i < 3; i++) begin
        if (roll < 45) f[i] = near_value(sb.held[i]);
        else if (roll < 55) f[i] = sb.held[i];
        else if (roll < 80) f[i] = force_t'($urandom);
        else f[i] = corner_value();
      end
      push_sample(f[0], f[1], f[2]);
    end
    settle();
  endtask

  initial begin
    sb = new();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    rst <= 1'b1;
    sample_ch.valid <= 1'b0;
    sample_ch.force_x <= '0;
    sample_ch.force_y <= '0;
    sample_ch.force_z <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.deadband_fraction <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset fraction: first word, zero words, full-scale words, inside and outside the band
    push_sample(16'sd100, -16'sd200, 16'sd300);
    push_sample(16'sd100, -16'sd200, 16'sd300);
    push_sample(16'sd101, -16'sd200, 16'sd300);
    push_sample(16'sd0, 16'sd0, 16'sd0);
    push_sample(16'sd0, 16'sd0, 16'sd0);
    push_sample(16'sd32767, 16'sd32767, 16'sd32767);
    push_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    push_sample(-16'sd32768, 16'sd32767, -16'sd32768);
    push_sample(16'sd32767, -16'sd32768, 16'sd0);
    push_sample(16'sd1, -16'sd1, 16'sd0);
    push_sample(-16'sd1, -16'sd1, -16'sd1);
    push_sample(16'sd20000, 16'sd0, 16'sd0);
    push_sample(16'sd23000, 16'sd0, 16'sd0);
    push_sample(16'sd26000, 16'sd0, 16'sd0);
    settle();

    // zero fraction: equal word holds, any change updates
    write_fraction(kfrac_t'(0));
    push_sample(16'sd26000, 16'sd0, 16'sd0);
    push_sample(16'sd26001, 16'sd0, 16'sd0);
    push_sample(16'sd0, 16'sd0, 16'sd0);
    push_sample(16'sd0, 16'sd0, 16'sd0);
    settle();

    // widest fraction
    write_fraction(kfrac_t'(1023));
    push_sample(16'sd1000, 16'sd2000, -16'sd3000);
    push_sample(16'sd1500, -16'sd500, 16'sd0);
    push_sample(-16'sd1500, 16'sd500, 16'sd0);
    push_sample(-16'sd1400, 16'sd500, 16'sd0);
    settle();

    write_fraction(kfrac_t'($urandom_range(1023)));
    run_random(RANDOM_WORDS, 34, 58);
    write_fraction(K_RESET);
    run_random(RANDOM_WORDS, 58, 34);
    write_fraction(kfrac_t'(1023));
    run_random(RANDOM_WORDS, 0, 0);
    write_fraction(kfrac_t'(0));
    run_random(RANDOM_WORDS, 34, 58);
    write_fraction(kfrac_t'($urandom_range(1023)));
    run_random(RANDOM_WORDS, 58, 34);
    write_fraction(kfrac_t'($urandom_range(60)));
    run_random(RANDOM_WORDS, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** perceptual_deadband_force_coder_unit: PASSED **");
    end else begin
      $display("** perceptual_deadband_force_coder_unit: FAILED **");
    end
    $finish;
  end

endmodule
